FILE: rtl/core/fld_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// fld_pkg
// Types and constants shared by the flag-driven LZ image decoder.
// -----------------------------------------------------------------------------
package fld_pkg;

   localparam int LANES_MAX = 8;
   localparam int ELEM_W    = 24;
   localparam int TOTAL_W   = 23;
   localparam int DIST_W    = 13;
   localparam int LEN_W     = 9;

   typedef enum logic [1:0] {
      CSR_MODE  = 2'd0,
      CSR_TOTAL = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_PIXEL   = 2'd0,
      MODE_MASK    = 2'd1,
      MODE_INDEXED = 2'd2,
      MODE_MASK_B  = 2'd3
   } mode_type;

   localparam logic REQ_DATA  = 1'b0;
   localparam logic REQ_TABLE = 1'b1;

   typedef struct packed {
      logic              req_type;
      logic [7:0]        in_byte;
      logic [3:0]        table_slot;
      logic [DIST_W-1:0] table_value;
   } fld_req_type;

   typedef struct packed {
      logic [ELEM_W-1:0] lane0;
      logic [ELEM_W-1:0] lane1;
      logic [ELEM_W-1:0] lane2;
      logic [ELEM_W-1:0] lane3;
      logic [ELEM_W-1:0] lane4;
      logic [ELEM_W-1:0] lane5;
      logic [ELEM_W-1:0] lane6;
      logic [ELEM_W-1:0] lane7;
      logic [3:0]        lane_count;
      logic              run_last;
      logic              image_done;
      logic              ref_error;
   } fld_rsp_type;

endpackage

FILE: rtl/core/fld_hist_ram.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// fld_hist_ram
// History window: one write port, one read port, registered read data.
// -----------------------------------------------------------------------------
module fld_hist_ram #(
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [23:0]              wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [23:0]              rd_data
);
   logic [23:0] mem [DEPTH];
   logic [23:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/core/flag_lz_image_decoder.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// flag_lz_image_decoder
// LZSS-style decoder: flag bytes select literals or back-references that
// copy from a history window; elements leave in groups of up to 8 lanes.
// -----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_ready | fld_req_type
//  rsp     | out       | rsp_valid/rsp_ready | fld_rsp_type
//  csr     | in        | csr_we              | csr_index, csr_wdata
//
// Each token element is a history read followed by a write-back of the
// registered read data. Reset (synchronous) clears decode state and the
// distance table; the history memory is not cleared. A stalled rsp holds
// the group in flight.
module flag_lz_image_decoder #(
   parameter int WINDOW_DEPTH = 4096,
   parameter int OUT_LANES    = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  fld_pkg::fld_req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output fld_pkg::fld_rsp_type rsp_data,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [22:0]         csr_wdata
);
   import fld_pkg::*;

   localparam int AW = $clog2(WINDOW_DEPTH);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_READ  = 4'b0010,
      ST_WRITE = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   logic [TOTAL_W-1:0]  pc_ff, pc_in;
   logic [7:0]          flag_ff, flag_in;
   logic [3:0]          tok_ff, tok_in;
   logic [1:0]          phase_ff, phase_in;
   logic [15:0]         part_ff, part_in;
   logic                fin_ff, fin_in;
   logic [1:0]          mode_ff, mode_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [DIST_W-1:0]   dtab_ff [16];
   logic [DIST_W-1:0]   dtab_in [16];
   logic [LEN_W-1:0]    left_ff, left_in;
   logic [DIST_W-1:0]   dist_ff, dist_in;
   logic                lit_ff, lit_in;
   logic [ELEM_W-1:0]   litv_ff, litv_in;
   logic                err_ff, err_in;
   logic [3:0]          cnt_ff, cnt_in;
   logic [ELEM_W-1:0]   lanes_ff [LANES_MAX];
   logic [ELEM_W-1:0]   lanes_in [LANES_MAX];
   fld_rsp_type         rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                mem_we;
   logic [AW-1:0]       mem_waddr, mem_raddr;
   logic [ELEM_W-1:0]   mem_wdata, mem_rdata;
   logic [TOTAL_W-1:0]  src_pos;

   logic [7:0]          b;
   logic                tok_lit;
   logic [1:0]          need;
   logic [23:0]         full;
   logic [LEN_W-1:0]    len_raw;
   logic [DIST_W-1:0]   dist_raw;
   logic [TOTAL_W-1:0]  room;
   logic [ELEM_W-1:0]   elem;
   logic [ELEM_W-1:0]   grp [LANES_MAX];

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign src_pos   = pc_ff - TOTAL_W'(dist_ff);
   assign mem_raddr = src_pos[AW-1:0];
   assign mem_waddr = pc_ff[AW-1:0];
   assign elem      = lit_ff ? litv_ff : (err_ff ? '0 : mem_rdata);
   assign mem_wdata = elem;
   assign mem_we    = (state_ff == ST_WRITE);

   fld_hist_ram #(.DEPTH(WINDOW_DEPTH)) u_hist (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // token decode from the current byte
   always_comb begin
      b       = req_data.in_byte;
      tok_lit = flag_ff[7];
      if (tok_lit) begin
         need = (mode_ff == MODE_PIXEL) ? 2'd3 : 2'd1;
      end else begin
         need = (mode_ff == MODE_INDEXED) ? 2'd1 : 2'd2;
      end
      full = {8'b0, part_ff} | ({16'b0, b} << (5'd8 * 5'(phase_ff)));
      unique case (mode_ff)
         MODE_PIXEL: begin
            len_raw  = LEN_W'(full[3:0]) + LEN_W'(1);
            dist_raw = DIST_W'(full[15:4]) + DIST_W'(1);
         end
         MODE_INDEXED: begin
            len_raw  = LEN_W'(full[7:4]) + LEN_W'(2);
            dist_raw = dtab_ff[full[3:0]];
         end
         default: begin
            len_raw  = LEN_W'(full[7:0]) + LEN_W'(2);
            dist_raw = DIST_W'(full[15:8]) + DIST_W'(1);
         end
      endcase
      room = total_ff - pc_ff;
   end

   always_comb begin
      for (int i = 0; i < LANES_MAX; i++) begin
         grp[i] = (i < OUT_LANES && 4'(i) < cnt_ff) ? lanes_ff[i] : '0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      flag_in      = flag_ff;
      tok_in       = tok_ff;
      phase_in     = phase_ff;
      part_in      = part_ff;
      fin_in       = fin_ff;
      mode_in      = mode_ff;
      total_in     = total_ff;
      dtab_in      = dtab_ff;
      left_in      = left_ff;
      dist_in      = dist_ff;
      lit_in       = lit_ff;
      litv_in      = litv_ff;
      err_in       = err_ff;
      cnt_in       = cnt_ff;
      lanes_in     = lanes_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               priority if (req_data.req_type == REQ_TABLE) begin
                  dtab_in[req_data.table_slot] = req_data.table_value;
               end else if (fin_ff || pc_ff >= total_ff) begin
                  fin_in = 1'b1;
               end else if (tok_ff == 4'd0) begin
                  flag_in = b;
                  tok_in  = 4'd8;
               end else if (phase_ff + 2'd1 < need) begin
                  part_in  = full[15:0];
                  phase_in = phase_ff + 2'd1;
               end else begin
                  phase_in = 2'd0;
                  part_in  = '0;
                  flag_in  = {flag_ff[6:0], 1'b0};
                  tok_in   = tok_ff - 4'd1;
                  lit_in   = tok_lit;
                  litv_in  = full;
                  dist_in  = dist_raw;
                  state_in = ST_READ;
                  if (tok_lit) begin
                     left_in = LEN_W'(1);
                     err_in  = 1'b0;
                  end else begin
                     left_in = (TOTAL_W'(len_raw) > room) ? room[LEN_W-1:0] : len_raw;
                     err_in  = (dist_raw == '0) || (TOTAL_W'(dist_raw) > pc_ff) ||
                               (32'(dist_raw) > 32'(WINDOW_DEPTH));
                  end
               end
            end
         end
         ST_READ: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            lanes_in[cnt_ff[2:0]] = elem;
            cnt_in  = cnt_ff + 4'd1;
            pc_in   = pc_ff + TOTAL_W'(1);
            left_in = left_ff - LEN_W'(1);
            if (cnt_ff + 4'd1 == 4'(OUT_LANES) || left_ff == LEN_W'(1)) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.lane0      = grp[0];
               rsp_in.lane1      = grp[1];
               rsp_in.lane2      = grp[2];
               rsp_in.lane3      = grp[3];
               rsp_in.lane4      = grp[4];
               rsp_in.lane5      = grp[5];
               rsp_in.lane6      = grp[6];
               rsp_in.lane7      = grp[7];
               rsp_in.lane_count = cnt_ff;
               rsp_in.run_last   = (left_ff == '0);
               rsp_in.image_done = (left_ff == '0) && (pc_ff >= total_ff);
               rsp_in.ref_error  = err_ff;
               rsp_valid_in      = 1'b1;
               cnt_in            = '0;
               if (left_ff == '0) begin
                  fin_in   = (pc_ff >= total_ff);
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // register writes restart decoding; the user must issue them only while idle, the block does not enforce it
      if (csr_we && (csr_index == CSR_MODE || csr_index == CSR_TOTAL)) begin
         if (csr_index == CSR_MODE) begin
            mode_in = csr_wdata[1:0];
         end else begin
            total_in = csr_wdata;
         end
         pc_in    = '0;
         flag_in  = '0;
         tok_in   = '0;
         phase_in = '0;
         part_in  = '0;
         fin_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         flag_ff      <= '0;
         tok_ff       <= '0;
         phase_ff     <= '0;
         part_ff      <= '0;
         fin_ff       <= 1'b0;
         mode_ff      <= MODE_PIXEL;
         total_ff     <= TOTAL_W'(307200);
         left_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 16; i++) begin
            dtab_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         flag_ff      <= flag_in;
         tok_ff       <= tok_in;
         phase_ff     <= phase_in;
         part_ff      <= part_in;
         fin_ff       <= fin_in;
         mode_ff      <= mode_in;
         total_ff     <= total_in;
         left_ff      <= left_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         dtab_ff      <= dtab_in;
      end
      dist_ff  <= dist_in;
      lit_ff   <= lit_in;
      litv_ff  <= litv_in;
      err_ff   <= err_in;
      lanes_ff <= lanes_in;
      rsp_ff   <= rsp_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.lane_count != 4'd0 &&
                        rsp_ff.lane_count <= 4'(OUT_LANES)))
      else $error("group lane count out of range");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.image_done |-> rsp_ff.run_last)
      else $error("image end on a group that is not the last of its request");

   a_lane_room: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WRITE |-> cnt_ff < 4'(OUT_LANES))
      else $error("lane buffer overflow");

   a_copy_ends: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WRITE && left_ff == LEN_W'(1) |=> state_ff == ST_EMIT)
      else $error("copy did not close its last group");
endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb
// Self-checking bench for flag_lz_image_decoder: builds flag/token streams in
// every decode mode, predicts the lane groups in a behavioral decoder, and
// compares each response with random stalls on both channels.
// -----------------------------------------------------------------------------
module tb;
   import fld_pkg::*;

   localparam int LIMIT = 3000000;
   localparam int HIST_D = 4096;
   localparam logic [1:0] CSR_UNUSED = 2'd2;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   fld_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   fld_rsp_type rsp_data;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [22:0] csr_wdata = '0;

   flag_lz_image_decoder dut (.*);

   always #10 clock = ~clock;

   // decoder shadow state
   logic [23:0] hist [HIST_D];
   logic [12:0] dist_tab [16];
   int unsigned produced, flags, tokens, phase, partial, total;
   bit          done_img;
   mode_type    mode;

   fld_req_type req_queue [$];
   fld_rsp_type group_queue [$];
   int  errors = 0, cycles = 0, req_gap = 0, rsp_stall = 0;
   bit  calm = 0;

   task automatic report(string what, int unsigned got, int unsigned want);
      errors++;
      $display("mismatch %s: got %0h expected %0h", what, got, want);
   endtask

   function automatic int draw_wait();
      return calm ? 0 : $urandom_range(0, 16);
   endfunction

   task automatic restart_decode();
      produced = 0; flags = 0; tokens = 0; phase = 0; partial = 0; done_img = 0;
   endtask

   task automatic store(int unsigned v);
      hist[produced % HIST_D] = v[23:0];
      produced = (produced + 1) & 32'h7FFFFF;
   endtask

   task automatic decode_request(fld_req_type r);
      int unsigned elems [257];
      logic [23:0] lanes [8];
      int unsigned b, need, full, len, back_dist, room, n, pos, cnt;
      bit lit, err;
      fld_rsp_type g;
      n = 0; err = 0;
      if (r.req_type == REQ_TABLE) begin
         dist_tab[r.table_slot] = r.table_value;
         return;
      end
      if (done_img || produced >= total) begin
         done_img = 1;
         return;
      end
      b = r.in_byte;
      if (tokens == 0) begin
         flags = b; tokens = 8;
         return;
      end
      lit = flags[7];
      if (lit) need = (mode == MODE_PIXEL) ? 3 : 1;
      else need = (mode == MODE_INDEXED) ? 1 : 2;
      if (phase + 1 < need) begin
         partial = (partial | (b << (8 * phase))) & 16'hFFFF;
         phase++;
         return;
      end
      full = partial | (b << (8 * phase));
      phase = 0; partial = 0;
      flags = (flags << 1) & 8'hFF;
      tokens--;
      if (lit) begin
         elems[0] = full & 24'hFFFFFF;
         store(elems[0]);
         n = 1;
      end else begin
         if (mode == MODE_PIXEL) begin
            len = (full & 4'hF) + 1;
            back_dist = ((full >> 4) & 12'hFFF) + 1;
         end else if (mode == MODE_INDEXED) begin
            len = ((full >> 4) & 4'hF) + 2;
            back_dist = dist_tab[full & 4'hF];
         end else begin
            len = (full & 8'hFF) + 2;
            back_dist = ((full >> 8) & 8'hFF) + 1;
         end
         room = total - produced;
         if (len > room) len = room;
         err = (back_dist == 0 || back_dist > produced || back_dist > HIST_D);
         for (int i = 0; i < len; i++) begin
            elems[i] = err ? 0 : hist[(produced - back_dist) % HIST_D];
            store(elems[i]);
         end
         n = len;
      end
      if (produced >= total) done_img = 1;
      pos = 0;
      while (pos < n) begin
         cnt = (n - pos > 8) ? 8 : n - pos;
         for (int k = 0; k < 8; k++) lanes[k] = (k < cnt) ? 24'(elems[pos + k]) : '0;
         pos += cnt;
         g = '0;
         g.lane0 = lanes[0]; g.lane1 = lanes[1]; g.lane2 = lanes[2]; g.lane3 = lanes[3];
         g.lane4 = lanes[4]; g.lane5 = lanes[5]; g.lane6 = lanes[6]; g.lane7 = lanes[7];
         g.lane_count = 4'(cnt);
         g.run_last = (pos >= n);
         g.image_done = (pos >= n) && done_img;
         g.ref_error = err;
         group_queue.push_back(g);
      end
   endtask

   task automatic send_byte(int unsigned b);
      fld_req_type r;
      r.req_type = REQ_DATA;
      r.in_byte = b[7:0];
      r.table_slot = 4'($urandom);
      r.table_value = 13'($urandom);
      decode_request(r);
      req_queue.push_back(r);
   endtask

   task automatic send_table(int unsigned slot, int unsigned val);
      fld_req_type r;
      r.req_type = REQ_TABLE;
      r.in_byte = 8'($urandom);
      r.table_slot = slot[3:0];
      r.table_value = val[12:0];
      decode_request(r);
      req_queue.push_back(r);
   endtask

   task automatic wait_idle();
      while (req_queue.size() != 0 || req_valid || group_queue.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, int unsigned val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[22:0];
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_MODE) begin
         mode = mode_type'(val[1:0]);
         restart_decode();
      end else if (idx == CSR_TOTAL) begin
         total = val & 32'h7FFFFF;
         restart_decode();
      end
   endtask

   // one token; mostly valid distances, sometimes a bad one
   task automatic send_token(bit lit);
      int unsigned d, cap, lf;
      bit good;
      good = ($urandom_range(0, 7) != 0);
      if (lit) begin
         send_byte($urandom);
         if (mode == MODE_PIXEL) begin
            send_byte($urandom);
            send_byte($urandom);
         end
      end else if (mode == MODE_INDEXED) begin
         send_byte($urandom);
      end else begin
         cap = (mode == MODE_PIXEL) ? HIST_D : 256;
         if (produced < cap) cap = produced;
         if (good && cap > 0) d = $urandom_range(1, cap);
         else d = $urandom_range(produced + 1, produced + 20);
         if (mode == MODE_PIXEL) begin
            if (d > HIST_D) d = HIST_D;
            lf = $urandom_range(0, 15);
            send_byte(((d - 1) << 4 | lf) & 8'hFF);
            send_byte(((d - 1) >> 4) & 8'hFF);
         end else begin
            if (d > 256) d = 256;
            send_byte(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                      : $urandom_range(0, 20));
            send_byte(d - 1);
         end
      end
   endtask

   task automatic send_block(int unsigned flag);
      send_byte(flag);
      for (int i = 7; i >= 0; i--) send_token(flag[i]);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (req_queue.size() != 0) begin
            req_data <= req_queue.pop_front();
            req_valid <= 1'b1;
            req_gap <= draw_wait();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         if (group_queue.size() == 0) begin
            report("unexpected group", rsp_data.lane_count, 0);
         end else begin
            fld_rsp_type w;
            w = group_queue.pop_front();
            if (rsp_data.lane0 !== w.lane0) report("lane0", rsp_data.lane0, w.lane0);
            if (rsp_data.lane1 !== w.lane1) report("lane1", rsp_data.lane1, w.lane1);
            if (rsp_data.lane2 !== w.lane2) report("lane2", rsp_data.lane2, w.lane2);
            if (rsp_data.lane3 !== w.lane3) report("lane3", rsp_data.lane3, w.lane3);
            if (rsp_data.lane4 !== w.lane4) report("lane4", rsp_data.lane4, w.lane4);
            if (rsp_data.lane5 !== w.lane5) report("lane5", rsp_data.lane5, w.lane5);
            if (rsp_data.lane6 !== w.lane6) report("lane6", rsp_data.lane6, w.lane6);
            if (rsp_data.lane7 !== w.lane7) report("lane7", rsp_data.lane7, w.lane7);
            if (rsp_data.lane_count !== w.lane_count)
               report("lane_count", rsp_data.lane_count, w.lane_count);
            if (rsp_data.run_last !== w.run_last)
               report("run_last", rsp_data.run_last, w.run_last);
            if (rsp_data.image_done !== w.image_done)
               report("image_done", rsp_data.image_done, w.image_done);
            if (rsp_data.ref_error !== w.ref_error)
               report("ref_error", rsp_data.ref_error, w.ref_error);
         end
         rsp_stall = draw_wait();
         rsp_ready <= (rsp_stall == 0);
      end else if (rsp_stall > 0) begin
         rsp_stall = rsp_stall - 1;
         rsp_ready <= (rsp_stall == 0);
      end else begin
         rsp_ready <= 1'b1;
      end
      if (cycles > LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      int unsigned totals [6] = '{4194304, 1, 60, 4194304, 37, 307200};
      int start;
      for (int i = 0; i < 16; i++) dist_tab[i] = '0;
      mode = MODE_PIXEL;
      total = 307200;
      restart_decode();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: pixel extremes, bad distance on a one-element history, overlap
      send_table(0, 0);
      send_table(15, 8191);
      send_byte(8'hB5);
      send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF);
      send_byte(8'h1F); send_byte(8'h00);          // distance 2 with 1 element: bad
      send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);
      send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF);
      send_byte(8'h0F); send_byte(8'h00);          // distance 1, length 16: repeat
      send_byte(8'h5A); send_byte(8'hA5); send_byte(8'h3C);
      send_byte(8'hFF); send_byte(8'hFF);          // distance 4096: bad
      send_byte(8'hC3);                            // partial literal
      wait_idle();
      csr_write(CSR_UNUSED, 3);
      csr_write(CSR_MODE, MODE_MASK_B);
      send_block(8'h81);
      wait_idle();

      for (int p = 0; p < 6; p++) begin
         calm = ($urandom_range(0, 3) == 0);
         csr_write(CSR_MODE, p % 4);
         csr_write(CSR_TOTAL, totals[p]);
         if (mode == MODE_INDEXED) begin
            for (int s = 0; s < 16; s++)
               send_table(s, (s == 0) ? 0 : (s == 15) ? 4096 : $urandom_range(1, 6));
         end
         start = req_queue.size();
         // k counts the bytes queued in this pass
         for (int k = 0; k < 60 && !done_img; k = req_queue.size() - start) begin
            if ($urandom_range(0, 15) == 0) begin
               send_byte($urandom);
            end else begin
               send_block($urandom);
            end
         end
         if (done_img) send_byte($urandom);   // ignored after the image end
         wait_idle();
      end

      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule
